// ----- rtl/core/multi_button_debounce_toggle_assert.svh -----
// Assertion macros for the multi-button debouncer.
// Included by the top level; depends on nothing else.
`ifndef MULTI_BUTTON_DEBOUNCE_TOGGLE_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCE_TOGGLE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MBDT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define MBDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/mbdt_pkg.sv -----
// Shared types and constants for the multi-button debouncer.
// No dependencies.
package mbdt_pkg;

  localparam int ACTION_W = 2;
  localparam int NOW_W    = 32;
  localparam int PIN_W    = 10;
  localparam int CH_W     = 4;
  localparam int DEB_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  // Bit positions inside the request word
  localparam int IN_ACT_LO = 0;
  localparam int IN_NOW_LO = IN_ACT_LO + ACTION_W;
  localparam int IN_PIN_LO = IN_NOW_LO + NOW_W;
  localparam int IN_CH_LO  = IN_PIN_LO + PIN_W;
  localparam int IN_TV_LO  = IN_CH_LO + CH_W;

  // Bit positions inside the result word
  localparam int OUT_TAKEN_LO = 0;
  localparam int OUT_PEND_LO  = 1;
  localparam int OUT_TOG_LO   = OUT_PEND_LO + PIN_W;
  localparam int OUT_DEB_LO   = OUT_TOG_LO + PIN_W;
  localparam int OUT_USED_W   = OUT_DEB_LO + PIN_W;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(10);

  typedef enum logic [ACTION_W-1:0] {
    ACT_SCAN = 2'd0,
    ACT_TAKE = 2'd1,
    ACT_SET  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_ACTIVE   = 2'd1,
    CFG_MASK     = 2'd2
  } cfg_idx_t;

  // Per-channel status returned by a debounce lane
  typedef struct packed {
    logic stable;       // current debounced level
    logic stable_next;  // debounced level after this request
    logic press;        // accepted edge to the active level
  } chan_stat_t;

endpackage

// ----- rtl/core/mbdt_chan.sv -----
// One debounce lane: raw-level history, change stamp and debounced level.
// Depends on mbdt_pkg.
module mbdt_chan #(
  parameter int TIME_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [TIME_BITS-1:0]        now,
  input  logic                        pin,
  input  logic [mbdt_pkg::DEB_W-1:0]  deb,
  input  logic                        active,
  output mbdt_pkg::chan_stat_t        stat
);

  localparam int CMP_W = (TIME_BITS > mbdt_pkg::DEB_W) ? TIME_BITS : mbdt_pkg::DEB_W;

  logic                 last_raw;
  logic                 stable;
  logic [TIME_BITS-1:0] stamp;
  logic [TIME_BITS-1:0] elapsed;
  logic                 expired;
  logic                 accept;

  // Elapsed time wraps with the clock counter; a fresh change restarts at zero
  assign elapsed = now - stamp;
  assign expired = CMP_W'(elapsed) > CMP_W'(deb);
  assign accept  = step && (pin == last_raw) && expired && (pin != stable);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw <= 1'b1;
      stable   <= 1'b1;
      stamp    <= '0;
    end else if (step) begin
      last_raw <= pin;
      if (pin != last_raw) begin
        stamp <= now;
      end
      if (accept) begin
        stable <= pin;
      end
    end
  end

  assign stat.stable      = stable;
  assign stat.stable_next = accept ? pin : stable;
  assign stat.press       = accept && (pin == active);

endmodule

// ----- rtl/core/multi_button_debounce_toggle.sv -----
// Multi-button debouncer with sticky press flags and toggle bits.
// A request passes the request register, then the result register.
// One request per cycle unless m_tready stalls; all channels work in parallel lanes.
// Reset: synchronous; raw and debounced levels go idle high, stamps, press flags
// and toggle bits clear, debounce_ms = 10, active_level = 0, toggle_mask = all ones.
// Depends on mbdt_pkg, mbdt_chan and multi_button_debounce_toggle_assert.svh.
`include "multi_button_debounce_toggle_assert.svh"

module multi_button_debounce_toggle #(
  parameter int CHANNELS  = 10,
  parameter int TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // Request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tdata, low bit up: action[1:0], now_ms[33:2], pin_levels[43:34],
  // channel[47:44], toggle_value[48], zero fill[55:49]
  input  logic [mbdt_pkg::IN_DATA_W-1:0]      s_tdata,
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tdata, low bit up: pressed_taken[0], pressed_pending[10:1],
  // toggle_levels[20:11], debounced_levels[30:21], zero fill[31]
  output logic [mbdt_pkg::OUT_DATA_W-1:0]     m_tdata,
  // Configuration writes
  input  logic                                cfg_we,
  input  logic [mbdt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbdt_pkg::DEB_W-1:0]          cfg_data
);

  localparam int PIN_W = mbdt_pkg::PIN_W;
  localparam int CH_W  = mbdt_pkg::CH_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [mbdt_pkg::DEB_W-1:0] debounce_ms;
  logic                       active_level;
  logic [CHANNELS-1:0]        toggle_mask;
  logic [CHANNELS-1:0]        mask_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms  <= mbdt_pkg::DEBOUNCE_RESET;
      active_level <= 1'b0;
      toggle_mask  <= '1;
    end else if (cfg_we) begin
      unique case (mbdt_pkg::cfg_idx_t'(cfg_index))
        mbdt_pkg::CFG_DEBOUNCE: debounce_ms  <= cfg_data;
        mbdt_pkg::CFG_ACTIVE:   active_level <= cfg_data[0];
        mbdt_pkg::CFG_MASK:     toggle_mask  <= mask_wr;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request register
  // ---------------------------------------------------------------------------
  logic                  s1_valid;
  mbdt_pkg::action_t     s1_action;
  logic [TIME_BITS-1:0]  s1_now;
  logic [PIN_W-1:0]      s1_pins;
  logic [CH_W-1:0]       s1_ch;
  logic                  s1_tv;
  logic                  advance;
  logic                  scan_step;

  // Process the held request whenever the result register is free or draining
  assign advance   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || advance;
  assign scan_step = advance && (s1_action == mbdt_pkg::ACT_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_action <= mbdt_pkg::action_t'(s_tdata[mbdt_pkg::IN_ACT_LO +: mbdt_pkg::ACTION_W]);
      s1_now    <= s_tdata[mbdt_pkg::IN_NOW_LO +: TIME_BITS];
      s1_pins   <= s_tdata[mbdt_pkg::IN_PIN_LO +: PIN_W];
      s1_ch     <= s_tdata[mbdt_pkg::IN_CH_LO +: CH_W];
      s1_tv     <= s_tdata[mbdt_pkg::IN_TV_LO];
    end
  end

  // ---------------------------------------------------------------------------
  // Debounce lanes, one per channel
  // ---------------------------------------------------------------------------
  mbdt_pkg::chan_stat_t  stat [CHANNELS];
  logic [CHANNELS-1:0]   pins_c;
  logic [CHANNELS-1:0]   ch_sel;
  logic [CHANNELS-1:0]   press_set;
  logic [CHANNELS-1:0]   stable_cur;
  logic [CHANNELS-1:0]   stable_next;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
    // Channels past the pin field see a low pin and take no mask write bit
    if (i < PIN_W) begin : g_pin
      assign pins_c[i]  = s1_pins[i];
      assign mask_wr[i] = cfg_data[i];
    end else begin : g_nopin
      assign pins_c[i]  = 1'b0;
      assign mask_wr[i] = 1'b0;
    end

    assign ch_sel[i]      = (s1_ch == CH_W'(i));
    assign press_set[i]   = stat[i].press;
    assign stable_cur[i]  = stat[i].stable;
    assign stable_next[i] = stat[i].stable_next;

    mbdt_chan #(
      .TIME_BITS (TIME_BITS)
    ) u_chan (
      .clk    (clk),
      .rst    (rst),
      .step   (scan_step),
      .now    (s1_now),
      .pin    (pins_c[i]),
      .deb    (debounce_ms),
      .active (active_level),
      .stat   (stat[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Press flags and toggle bits
  // ---------------------------------------------------------------------------
  logic [CHANNELS-1:0] press_flags;
  logic [CHANNELS-1:0] press_flags_next;
  logic [CHANNELS-1:0] toggle_bits;
  logic [CHANNELS-1:0] toggle_bits_next;
  logic                taken_next;

  // An out-of-range channel matches no select bit, so take and set fall
  // through with no effect and take answers zero.
  always_comb begin
    press_flags_next = press_flags | press_set;
    toggle_bits_next = toggle_bits ^ (press_set & toggle_mask);
    taken_next       = 1'b0;
    unique case (s1_action)
      mbdt_pkg::ACT_SCAN: ;
      mbdt_pkg::ACT_TAKE: begin
        taken_next       = |(press_flags & ch_sel);
        press_flags_next = press_flags & ~ch_sel;
      end
      mbdt_pkg::ACT_SET: begin
        toggle_bits_next = s1_tv ? (toggle_bits | ch_sel) : (toggle_bits & ~ch_sel);
      end
      default: ;  // unused action: hold all state
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_flags <= '0;
      toggle_bits <= '0;
    end else if (advance) begin
      press_flags <= press_flags_next;
      toggle_bits <= toggle_bits_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [PIN_W-1:0] press_next_p;
  logic [PIN_W-1:0] toggle_next_p;
  logic [PIN_W-1:0] stable_next_p;
  logic [PIN_W-1:0] toggle_p;
  logic [PIN_W-1:0] stable_p;

  // Fit channel vectors to the fixed result field width
  for (genvar j = 0; j < PIN_W; j++) begin : g_out
    if (j < CHANNELS) begin : g_has
      assign press_next_p[j]  = press_flags_next[j];
      assign toggle_next_p[j] = toggle_bits_next[j];
      assign stable_next_p[j] = stable_next[j];
      assign toggle_p[j]      = toggle_bits[j];
      assign stable_p[j]      = stable_cur[j];
    end else begin : g_none
      assign press_next_p[j]  = 1'b0;
      assign toggle_next_p[j] = 1'b0;
      assign stable_next_p[j] = 1'b0;
      assign toggle_p[j]      = 1'b0;
      assign stable_p[j]      = 1'b0;
    end
  end

  logic             out_taken;
  logic [PIN_W-1:0] out_pending;
  logic [PIN_W-1:0] out_toggle;
  logic [PIN_W-1:0] out_debounced;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_taken     <= taken_next;
      out_pending   <= press_next_p;
      out_toggle    <= toggle_next_p;
      out_debounced <= stable_next_p;
    end
  end

  assign m_tdata = {(mbdt_pkg::OUT_DATA_W - mbdt_pkg::OUT_USED_W)'(0),
                    out_debounced, out_toggle, out_pending, out_taken};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Only a take request may report a taken flag
  `MBDT_ASSERT_NEXT(a_taken_only_on_take, clk, rst,
    advance && (s1_action != mbdt_pkg::ACT_TAKE), !out_taken,
    "pressed_taken set by a request that is not a take")

  // Press flags only clear through a take request
  `MBDT_ASSERT_NEXT(a_press_sticky, clk, rst,
    advance && (s1_action != mbdt_pkg::ACT_TAKE),
    (press_flags & $past(press_flags)) == $past(press_flags),
    "press flag cleared outside a take request")

  // A pending result always shows the live toggle and debounced state
  `MBDT_ASSERT_NOW(a_result_matches_state, clk, rst,
    m_tvalid, (out_toggle == toggle_p) && (out_debounced == stable_p),
    "held result disagrees with current state")

endmodule

// ----- tb/tb_multi_button_debounce_toggle.sv -----
// Self-checking testbench for multi_button_debounce_toggle: directed rows, then random
// scan, take, set and spare traffic under several register settings with random stalls.
// Depends on mbdt_pkg and the RTL top level only.
module tb_multi_button_debounce_toggle;
  timeunit 1ns;
  timeprecision 1ps;
  import mbdt_pkg::*;

  localparam int NCH          = 10;
  localparam int LIMIT_CYCLES = 400000;

  // Codes the package leaves unnamed: the spare action and the spare register slot
  localparam action_t  ACT_SPARE = action_t'(2'd3);
  localparam cfg_idx_t CFG_SPARE = cfg_idx_t'(2'd3);

  typedef struct packed {
    action_t          act;
    logic [NOW_W-1:0] now;
    logic [PIN_W-1:0] pins;
    logic [CH_W-1:0]  chan;
    logic             tv;
  } request_t;

  typedef struct packed {
    logic             taken;
    logic [PIN_W-1:0] pending;
    logic [PIN_W-1:0] toggles;
    logic [PIN_W-1:0] levels;
  } button_status_t;

  typedef struct {
    request_t       rq;
    bit             typed;
    button_status_t want;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [DEB_W-1:0]      cfg_data;

  // Typed-in expectation that travels with the request it belongs to
  logic                  typed_row;
  button_status_t        typed_want;

  multi_button_debounce_toggle u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model state of the debouncer and its registers
  logic [PIN_W-1:0] raw_seen;
  logic [PIN_W-1:0] levels_now;
  logic [NOW_W-1:0] stamps [NCH];
  logic [PIN_W-1:0] flags_now;
  logic [PIN_W-1:0] toggles_now;
  logic [DEB_W-1:0] deb_cfg;
  logic             act_cfg;
  logic [PIN_W-1:0] mask_cfg;

  button_status_t status_due [$];
  plan_row_t      plan_rows [$];

  int  err_count;
  int  requests_sent;
  int  statuses_checked;
  int  presses_taken;
  int  settings_run;
  int  cycle_count;
  bit  quiet;
  bit  gaps_on;

  // Stimulus shaping: a held pin pattern, a running clock and the phase's delay
  logic [PIN_W-1:0] pin_target;
  logic [NOW_W-1:0] now_track;
  logic [DEB_W-1:0] phase_deb;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the model by one request and return the status it must produce.
  function automatic button_status_t advance_buttons(request_t rq);
    button_status_t st;
    logic [NOW_W-1:0] elapsed;
    st = '0;
    case (rq.act)
      ACT_SCAN: begin
        for (int i = 0; i < NCH; i++) begin
          // A raw edge restarts the channel's quiet-time clock
          if (rq.pins[i] != raw_seen[i]) stamps[i] = rq.now;
          elapsed = rq.now - stamps[i];
          if (elapsed > NOW_W'(deb_cfg) && rq.pins[i] != levels_now[i]) begin
            levels_now[i] = rq.pins[i];
            if (rq.pins[i] == act_cfg) begin
              flags_now[i] = 1'b1;
              if (mask_cfg[i]) toggles_now[i] = ~toggles_now[i];
            end
          end
        end
        raw_seen = rq.pins;
      end
      ACT_TAKE: begin
        if (rq.chan < NCH) begin
          st.taken = flags_now[rq.chan];
          flags_now[rq.chan] = 1'b0;
        end
      end
      ACT_SET: begin
        if (rq.chan < NCH) toggles_now[rq.chan] = rq.tv;
      end
      default: ;
    endcase
    st.pending = flags_now;
    st.toggles = toggles_now;
    st.levels  = levels_now;
    return st;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] mismatch on %0s: got %0h, want %0h (status %0d)",
             $realtime, what, got, want, statuses_checked);
    err_count++;
  endtask

  // Watch both streams and the register port at every rising edge.
  always @(posedge clk) begin : watch
    button_status_t got;
    button_status_t want;
    request_t rq;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d statuses still due", cycle_count,
               status_due.size());
      $display("*** FAILED ***");
      $finish;
    end
    if (rst) begin
      raw_seen    = '1;
      levels_now  = '1;
      flags_now   = '0;
      toggles_now = '0;
      for (int i = 0; i < NCH; i++) stamps[i] = '0;
      deb_cfg  = DEBOUNCE_RESET;
      act_cfg  = 1'b0;
      mask_cfg = '1;
    end else begin
      // Check the result side first: a request taken at this edge cannot answer yet
      if (m_tvalid && m_tready) begin
        got.taken   = m_tdata[OUT_TAKEN_LO];
        got.pending = m_tdata[OUT_PEND_LO +: PIN_W];
        got.toggles = m_tdata[OUT_TOG_LO +: PIN_W];
        got.levels  = m_tdata[OUT_DEB_LO +: PIN_W];
        if (status_due.size() == 0) begin
          flag_mismatch("unexpected status", m_tdata, '0);
        end else begin
          want = status_due.pop_front();
          if (got.taken !== want.taken)
            flag_mismatch("pressed_taken", 32'(got.taken), 32'(want.taken));
          if (got.pending !== want.pending)
            flag_mismatch("pressed_pending", 32'(got.pending), 32'(want.pending));
          if (got.toggles !== want.toggles)
            flag_mismatch("toggle_levels", 32'(got.toggles), 32'(want.toggles));
          if (got.levels !== want.levels)
            flag_mismatch("debounced_levels", 32'(got.levels), 32'(want.levels));
          if (m_tdata[OUT_DATA_W-1:OUT_USED_W] !== '0)
            flag_mismatch("zero fill", 32'(m_tdata[OUT_DATA_W-1:OUT_USED_W]), '0);
        end
        if (got.taken === 1'b1) presses_taken++;
        statuses_checked++;
      end
      // Predict from what the block actually accepted
      if (s_tvalid && s_tready) begin
        rq.act  = action_t'(s_tdata[IN_ACT_LO +: ACTION_W]);
        rq.now  = s_tdata[IN_NOW_LO +: NOW_W];
        rq.pins = s_tdata[IN_PIN_LO +: PIN_W];
        rq.chan = s_tdata[IN_CH_LO +: CH_W];
        rq.tv   = s_tdata[IN_TV_LO];
        want = advance_buttons(rq);
        status_due.push_back(typed_row ? typed_want : want);
      end
      // Register writes; upper bits beyond each register are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE: deb_cfg  = cfg_data;
          CFG_ACTIVE:   act_cfg  = cfg_data[0];
          CFG_MASK:     mask_cfg = cfg_data[PIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result side: random stall bursts, long ready stretches, none in the quiet tail.
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // Present one request and hold it until the handshake; maybe idle afterwards.
  task automatic send_request(input request_t rq, input bit typed, input button_status_t want);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[IN_ACT_LO +: ACTION_W] = rq.act;
    word[IN_NOW_LO +: NOW_W]    = rq.now;
    word[IN_PIN_LO +: PIN_W]    = rq.pins;
    word[IN_CH_LO +: CH_W]      = rq.chan;
    word[IN_TV_LO]              = rq.tv;
    s_tdata    <= word;
    s_tvalid   <= 1'b1;
    typed_row  <= typed;
    typed_want <= want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    if ($urandom_range(0, 49) == 0) gaps_on = !gaps_on;
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every predicted status has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
  endtask

  // Build one random request. Scans mostly follow a held pattern with occasional
  // bounce, and time steps cluster around the debounce threshold.
  task automatic roll_request(output request_t rq);
    int pick;
    logic [NOW_W-1:0] step;
    pick    = $urandom_range(0, 99);
    rq.now  = $urandom;
    rq.pins = PIN_W'($urandom);
    rq.tv   = 1'($urandom_range(0, 1));
    rq.chan = ($urandom_range(0, 7) == 0) ? CH_W'($urandom_range(NCH, 15))
                                          : CH_W'($urandom_range(0, NCH - 1));
    if (pick < 62) begin
      rq.act = ACT_SCAN;
      case ($urandom_range(0, 7))
        0: pin_target[$urandom_range(0, NCH - 1)] = ~pin_target[$urandom_range(0, NCH - 1)];
        1: pin_target = pin_target ^ (PIN_W'($urandom) & PIN_W'($urandom));
        default: ;
      endcase
      rq.pins = ($urandom_range(0, 6) == 0) ? pin_target ^ PIN_W'($urandom) : pin_target;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: step = NOW_W'($urandom_range(0, 3));
        4, 5, 6:    step = NOW_W'(phase_deb) + NOW_W'($urandom_range(0, 2)) - 1;
        7, 8:       step = NOW_W'($urandom_range(0, 2 * int'(phase_deb) + 4));
        default:    step = $urandom;
      endcase
      now_track = now_track + step;
      rq.now = now_track;
    end else if (pick < 82) begin
      rq.act = ACT_TAKE;
    end else if (pick < 95) begin
      rq.act = ACT_SET;
    end else begin
      rq.act = ACT_SPARE;
    end
  endtask

  // Settle, rewrite every register, then run a stretch of random requests.
  task automatic run_phase(input logic [DEB_W-1:0] deb, input logic act,
                           input logic [PIN_W-1:0] mask, input int count,
                           input bit hold_mid, input bit poke_spare);
    request_t rq;
    drain_results();
    phase_deb = deb;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data  <= deb;
    @(posedge clk);
    cfg_index <= CFG_ACTIVE;
    cfg_data  <= {15'($urandom), act};
    @(posedge clk);
    cfg_index <= CFG_MASK;
    cfg_data  <= {6'($urandom), mask};
    @(posedge clk);
    if (poke_spare) begin
      // A write to the unused slot must leave all three registers alone
      cfg_index <= CFG_SPARE;
      cfg_data  <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_run++;
    for (int k = 0; k < count; k++) begin
      if (hold_mid && k == count / 2) drain_results();
      roll_request(rq);
      send_request(rq, 1'b0, '0);
    end
  endtask

  // Queue one directed row; typed rows carry their own expected status.
  task automatic add_row(input action_t act, input logic [NOW_W-1:0] now,
                         input logic [PIN_W-1:0] pins, input logic [CH_W-1:0] chan,
                         input logic tv, input bit typed, input logic taken,
                         input logic [PIN_W-1:0] pend, input logic [PIN_W-1:0] tog,
                         input logic [PIN_W-1:0] lev);
    plan_row_t row;
    row.rq    = '{act: act, now: now, pins: pins, chan: chan, tv: tv};
    row.typed = typed;
    row.want  = '{taken: taken, pending: pend, toggles: tog, levels: lev};
    plan_rows.push_back(row);
  endtask

  initial begin
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_DEBOUNCE;
    cfg_data   <= '0;
    typed_row  <= 1'b0;
    typed_want <= '0;
    rst        <= 1'b1;
    quiet      = 1'b0;
    gaps_on    = 1'b1;
    pin_target = '1;
    now_track  = '0;
    phase_deb  = DEBOUNCE_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at the reset settings (10 ms, active low, all toggles on).
    // Idle pins after reset: nothing moves.
    add_row(ACT_SCAN, 32'd0, 10'h3FF, 4'd0, 1'b0, 1, 1'b0, 10'h000, 10'h000, 10'h3FF);
    add_row(ACT_TAKE, 32'd0, 10'h000, 4'd0, 1'b0, 1, 1'b0, 10'h000, 10'h000, 10'h3FF);
    // Press every button at once; 10 ms elapsed is not enough, 11 ms is
    add_row(ACT_SCAN, 32'd100, 10'h000, 4'd0, 1'b0, 1, 1'b0, 10'h000, 10'h000, 10'h3FF);
    add_row(ACT_SCAN, 32'd110, 10'h000, 4'd0, 1'b0, 1, 1'b0, 10'h000, 10'h000, 10'h3FF);
    add_row(ACT_SCAN, 32'd111, 10'h000, 4'd0, 1'b0, 1, 1'b0, 10'h3FF, 10'h3FF, 10'h000);
    // Take the top flag twice: set, then cleared
    add_row(ACT_TAKE, 32'd0, 10'h000, 4'd9, 1'b0, 1, 1'b1, 10'h1FF, 10'h3FF, 10'h000);
    add_row(ACT_TAKE, 32'd0, 10'h000, 4'd9, 1'b0, 1, 1'b0, 10'h1FF, 10'h3FF, 10'h000);
    // Channel out of range: take reads false, set changes nothing
    add_row(ACT_TAKE, 32'd0, 10'h000, 4'd15, 1'b0, 1, 1'b0, 10'h1FF, 10'h3FF, 10'h000);
    add_row(ACT_SET, 32'd0, 10'h000, 4'd15, 1'b0, 1, 1'b0, 10'h1FF, 10'h3FF, 10'h000);
    add_row(ACT_SET, 32'd0, 10'h000, 4'd0, 1'b0, 1, 1'b0, 10'h1FF, 10'h3FE, 10'h000);
    add_row(ACT_SET, 32'd0, 10'h000, 4'd0, 1'b1, 1, 1'b0, 10'h1FF, 10'h3FF, 10'h000);
    // Spare action code with every field but the channel at its top: no state change
    add_row(ACT_SPARE, 32'hFFFF_FFFF, 10'h3FF, 4'd9, 1'b1, 1, 1'b0, 10'h1FF, 10'h3FF,
            10'h000);
    // Release across the time wrap, then bounce and settle half the buttons
    add_row(ACT_SCAN, 32'hFFFF_FFF0, 10'h3FF, 4'd0, 1'b0, 0, 1'b0, '0, '0, '0);
    add_row(ACT_SCAN, 32'h0000_0005, 10'h3FF, 4'd0, 1'b0, 0, 1'b0, '0, '0, '0);
    add_row(ACT_SCAN, 32'd6, 10'h2AA, 4'd0, 1'b0, 0, 1'b0, '0, '0, '0);
    add_row(ACT_SCAN, 32'd8, 10'h155, 4'd0, 1'b0, 0, 1'b0, '0, '0, '0);
    add_row(ACT_SCAN, 32'd30, 10'h155, 4'd0, 1'b0, 0, 1'b0, '0, '0, '0);
    add_row(ACT_TAKE, 32'd0, 10'h000, 4'd0, 1'b0, 0, 1'b0, '0, '0, '0);
    add_row(ACT_TAKE, 32'd0, 10'h000, 4'd1, 1'b0, 0, 1'b0, '0, '0, '0);
    add_row(ACT_SET, 32'd0, 10'h000, 4'd10, 1'b1, 0, 1'b0, '0, '0, '0);
    add_row(ACT_SCAN, 32'hFFFF_FFFF, 10'h3FF, 4'd0, 1'b0, 0, 1'b0, '0, '0, '0);
    add_row(ACT_SCAN, 32'h0000_000A, 10'h3FF, 4'd0, 1'b0, 0, 1'b0, '0, '0, '0);
    foreach (plan_rows[i]) send_request(plan_rows[i].rq, plan_rows[i].typed, plan_rows[i].want);

    now_track = 32'd1000;
    // Random phases; extremes of every register, then a stall-free tail.
    // Pause the sender halfway through the first one until all statuses are back.
    run_phase(DEBOUNCE_RESET, 1'b0, 10'h3FF, 340, 1'b1, 1'b0);
    run_phase(16'd0, 1'b1, 10'h000, 300, 1'b0, 1'b0);
    run_phase(16'hFFFF, 1'b0, 10'h3FF, 260, 1'b0, 1'b1);
    run_phase(16'd3, 1'b1, PIN_W'($urandom), 340, 1'b0, 1'b0);
    run_phase(DEB_W'($urandom_range(0, 40)), 1'b0, 10'h155, 300, 1'b0, 1'b0);
    quiet = 1'b1;
    run_phase(DEBOUNCE_RESET, 1'($urandom_range(0, 1)), PIN_W'($urandom), 290, 1'b0, 1'b0);

    // Let the last statuses arrive, then wait for anything stray
    drain_results();
    repeat (6) @(posedge clk);

    $display("ran %0d requests under %0d register settings (reset one included)",
             requests_sent, settings_run + 1);
    $display("checked %0d statuses, %0d takes found a press, %0d mismatches",
             statuses_checked, presses_taken, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mbdt_pkg.sv
rtl/core/mbdt_chan.sv
rtl/core/multi_button_debounce_toggle.sv
tb/tb_multi_button_debounce_toggle.sv
